/* rtl/aspb_pkg.sv */
package aspb_pkg;

  localparam int RECORDS_PER_REPORT = 10;
  localparam int CNT_W = $clog2(RECORDS_PER_REPORT + 1);
  localparam int IDX_W = (RECORDS_PER_REPORT > 1) ? $clog2(RECORDS_PER_REPORT) : 1;

  localparam int REC_W   = 40;
  localparam int SEQ_W   = 16;
  localparam int NFC_W   = 16;
  localparam int HELD_W  = 4;
  localparam int LEVEL_W = 7;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] NIBBLE_MASK    = 8'hF0;
  localparam logic [7:0] ECHO_RESET     = 8'h90;
  localparam logic [LEVEL_W-1:0] NEAR_FULL_RESET = 7'd31;
  localparam logic [LEVEL_W-1:0] FIFO_MAX_LEVEL  = 7'd32;

  typedef enum logic [1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_FLUSH   = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_STATUS  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ECHO      = 2'd0,
    REG_NEAR_FULL = 2'd1
  } cfg_reg_t;

  // Datapath action of one microcode step.
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_FETCH,
    ACT_STORE,
    ACT_RD_INIT,
    ACT_EMIT_REC,
    ACT_RPT_END,
    ACT_NF_CHECK,
    ACT_EMIT_ACK,
    ACT_EMIT_STAT,
    ACT_CLEAR
  } act_t;

  // Branch condition: when true go to target, else fall through.
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NOT_FULL,
    CND_MORE_REC,
    CND_FLUSH,
    CND_HELD,
    CND_DISPATCH
  } cond_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_FETCH    = 4'd0;
  localparam upc_t UA_STORE    = 4'd1;
  localparam upc_t UA_CHK_FULL = 4'd2;
  localparam upc_t UA_RD_INIT  = 4'd3;
  localparam upc_t UA_RD_WAIT  = 4'd4;
  localparam upc_t UA_EMIT_REC = 4'd5;
  localparam upc_t UA_RPT_END  = 4'd6;
  localparam upc_t UA_NF_CHECK = 4'd7;
  localparam upc_t UA_ACK      = 4'd8;
  localparam upc_t UA_FLUSH    = 4'd9;
  localparam upc_t UA_STATUS   = 4'd10;
  localparam upc_t UA_RESTART  = 4'd11;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    unique case (addr)
      UA_FETCH:    w = '{ACT_FETCH,     CND_DISPATCH, UA_FETCH};
      UA_STORE:    w = '{ACT_STORE,     CND_NEVER,    UA_FETCH};
      UA_CHK_FULL: w = '{ACT_NOP,       CND_NOT_FULL, UA_NF_CHECK};
      UA_RD_INIT:  w = '{ACT_RD_INIT,   CND_NEVER,    UA_FETCH};
      UA_RD_WAIT:  w = '{ACT_NOP,       CND_NEVER,    UA_FETCH};
      UA_EMIT_REC: w = '{ACT_EMIT_REC,  CND_MORE_REC, UA_RD_WAIT};
      UA_RPT_END:  w = '{ACT_RPT_END,   CND_FLUSH,    UA_STATUS};
      UA_NF_CHECK: w = '{ACT_NF_CHECK,  CND_NEVER,    UA_FETCH};
      UA_ACK:      w = '{ACT_EMIT_ACK,  CND_ALWAYS,   UA_FETCH};
      UA_FLUSH:    w = '{ACT_NOP,       CND_HELD,     UA_RD_INIT};
      UA_STATUS:   w = '{ACT_EMIT_STAT, CND_ALWAYS,   UA_FETCH};
      UA_RESTART:  w = '{ACT_CLEAR,     CND_ALWAYS,   UA_FETCH};
      default:     w = '{ACT_NOP,       CND_ALWAYS,   UA_FETCH};
    endcase
    return w;
  endfunction

  // Entry point of each function's microroutine.
  function automatic upc_t dispatch(input func_t f);
    upc_t a;
    unique case (f)
      FUNC_SAMPLE:  a = UA_STORE;
      FUNC_FLUSH:   a = UA_FLUSH;
      FUNC_RESTART: a = UA_RESTART;
      FUNC_STATUS:  a = UA_STATUS;
      default:      a = UA_FETCH;
    endcase
    return a;
  endfunction

endpackage

/* rtl/accel_sample_pack_batcher_unit.sv */
// Accelerometer sample pack batcher.
// Input stream (s_*): one beat per command. s_tuser carries the function
// (sample burst, flush, restart, status); s_tdata carries the raw burst bytes.
// Output stream (m_*): result beats; m_tuser is the result kind (ack, report
// record, status) and m_tlast marks the final beat caused by one command.
// Config port (cfg_*): always ready; index 0 is the expected control echo,
// index 1 the near-full FIFO level. Write only while the block is idle.
// Control is a microcode ROM stepped by a micro-PC; a command is taken only
// at the fetch step, so one command is in flight at a time.
// Emitting a report uses the buffer's one registered read port: the report
// loop spends one read step and one emit step per record. The output
// register lets the next command enter while the last result beat still
// waits. When the output register is full and m_tready is low the sequencer
// holds at its emit step. Reset clears counters, the buffer fill count, the
// sequencer and both config registers to their defaults; buffer contents
// are not cleared.
module accel_sample_pack_batcher_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Command beat
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high, control_echo, fifo_raw
  input  logic [aspb_pkg::IN_DATA_W-1:0]      s_tdata,
  // func
  input  logic [1:0]                          s_tuser,
  // Result beat
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // record, report_number, buffered, near_full_count, more_pending,
  // data_error, zero pad
  output logic [aspb_pkg::OUT_DATA_W-1:0]     m_tdata,
  // kind
  output logic [1:0]                          m_tuser,
  output logic                                m_tlast,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aspb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aspb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import aspb_pkg::*;

  // Config registers
  logic [7:0]          echo_cfg;
  logic [LEVEL_W-1:0]  near_full_cfg;

  // Sequencer
  upc_t   upc, upc_next;
  uword_t uw;

  // Latched command
  func_t              func;
  logic [REC_W-1:0]   rec;
  logic               err;
  logic               more;
  logic [LEVEL_W-1:0] level;

  // Counters and report walk
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   idx;
  logic [SEQ_W-1:0]   seq;
  logic [NFC_W-1:0]   nfc;

  // Record buffer
  logic [REC_W-1:0]   buf_mem [RECORDS_PER_REPORT];
  logic [REC_W-1:0]   rd_data;

  // Burst checks
  logic [7:0]         xh, yh, zh;
  logic               in_err;
  logic [LEVEL_W-1:0] in_level;
  logic [REC_W-1:0]   in_rec;

  logic in_accept, out_free, is_emit, stall, take;
  logic [CNT_W-1:0] idx_inc;

  assign cfg_ready = 1'b1;

  assign uw        = ucode(upc);
  assign s_tready  = (upc == UA_FETCH);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign is_emit   = (uw.act == ACT_EMIT_REC) || (uw.act == ACT_EMIT_ACK) ||
                     (uw.act == ACT_EMIT_STAT);
  assign stall     = is_emit && !out_free;
  assign idx_inc   = idx + CNT_W'(1);

  // Validate the burst and pack its record
  assign xh       = s_tdata[15:8];
  assign yh       = s_tdata[31:24];
  assign zh       = s_tdata[47:40];
  assign in_level = s_tdata[62:56];
  assign in_err   = ((xh & NIBBLE_MASK) != 8'h00 && (xh & NIBBLE_MASK) != NIBBLE_MASK) ||
                    ((yh & NIBBLE_MASK) != 8'h00 && (yh & NIBBLE_MASK) != NIBBLE_MASK) ||
                    ((zh & NIBBLE_MASK) != 8'h00 && (zh & NIBBLE_MASK) != NIBBLE_MASK) ||
                    (s_tdata[55:48] != echo_cfg) || (in_level > FIFO_MAX_LEVEL);
  assign in_rec   = {1'b0, zh[4:3], yh[4:0], zh[2:0], xh[4:0],
                     s_tdata[39:32], s_tdata[23:16], s_tdata[7:0]};

  // Branch resolution
  always_comb begin
    take = 1'b0;
    case (uw.cond)
      CND_NEVER:    take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_NOT_FULL: take = (cnt < CNT_W'(RECORDS_PER_REPORT));
      CND_MORE_REC: take = (idx_inc != cnt);
      CND_FLUSH:    take = (func == FUNC_FLUSH);
      CND_HELD:     take = (cnt != '0);
      CND_DISPATCH: take = 1'b0;
      default:      take = 1'b0;
    endcase

    if (uw.cond == CND_DISPATCH) begin
      upc_next = in_accept ? dispatch(func_t'(s_tuser)) : upc;
    end else if (stall) begin
      upc_next = upc;
    end else if (take) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  // Buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (uw.act == ACT_STORE) begin
      buf_mem[cnt[IDX_W-1:0]] <= rec;
    end
    rd_data <= buf_mem[idx[IDX_W-1:0]];
  end

  // Command latch
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func  <= func_t'(s_tuser);
      err   <= in_err;
      rec   <= in_err ? {REC_W{1'b1}} : in_rec;
      level <= in_err ? '0 : in_level;
      more  <= !in_err && (in_level > LEVEL_W'(1));
    end
  end

  // Control, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      upc           <= UA_FETCH;
      cnt           <= '0;
      idx           <= '0;
      seq           <= '0;
      nfc           <= '0;
      echo_cfg      <= ECHO_RESET;
      near_full_cfg <= NEAR_FULL_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      upc <= upc_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ECHO:      echo_cfg      <= cfg_data;
          REG_NEAR_FULL: near_full_cfg <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (uw.act)
        ACT_STORE:    cnt <= cnt + CNT_W'(1);
        ACT_RD_INIT:  idx <= '0;
        ACT_EMIT_REC: begin
          if (out_free) begin
            idx      <= idx_inc;
            m_tvalid <= 1'b1;
          end
        end
        ACT_RPT_END: begin
          cnt <= '0;
          seq <= seq + SEQ_W'(1);
        end
        ACT_NF_CHECK: begin
          if (level >= near_full_cfg) begin
            nfc <= nfc + NFC_W'(1);
          end
        end
        ACT_EMIT_ACK, ACT_EMIT_STAT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
          end
        end
        ACT_CLEAR: begin
          cnt <= '0;
          seq <= '0;
          nfc <= '0;
        end
        ACT_NOP, ACT_FETCH: ;
        default: ;
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (is_emit && out_free) begin
      m_tdata[OUT_DATA_W-1:78] <= '0;
      m_tdata[55:40]           <= seq;
      m_tdata[59:56]           <= HELD_W'(cnt);
      m_tdata[75:60]           <= nfc;
      if (uw.act == ACT_EMIT_REC) begin
        m_tdata[39:0] <= rd_data;
        m_tdata[76]   <= 1'b0;
        m_tdata[77]   <= 1'b0;
        m_tuser       <= KIND_REPORT;
        m_tlast       <= 1'b0;
      end else if (uw.act == ACT_EMIT_ACK) begin
        m_tdata[39:0] <= '0;
        m_tdata[76]   <= more;
        m_tdata[77]   <= err;
        m_tuser       <= KIND_ACK;
        m_tlast       <= 1'b1;
      end else begin
        m_tdata[39:0] <= '0;
        m_tdata[76]   <= 1'b0;
        m_tdata[77]   <= 1'b0;
        m_tuser       <= KIND_STATUS;
        m_tlast       <= 1'b1;
      end
    end
  end

  // Fill count never passes the buffer depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(RECORDS_PER_REPORT))
    else $error("buffer fill count above depth");

  // Closing a report empties the buffer
  a_rpt_empty: assert property (@(posedge clk) disable iff (rst)
    (upc == UA_RPT_END) |=> (cnt == '0))
    else $error("buffer not empty after report");

  // A report beat always comes from a nonempty buffer and is never last
  a_rpt_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_REPORT) |-> (m_tdata[59:56] != '0 && !m_tlast))
    else $error("bad report beat");

  // A command is taken only with the sequencer back at fetch
  a_fetch_only: assert property (@(posedge clk) disable iff (rst)
    (upc != UA_FETCH) |-> !s_tready)
    else $error("command accepted mid-routine");

endmodule
